FILE: hw/rtl/amj_pkg.sv
// Package for the as-of merge join: widths, operation codes, config register indices.
// No dependencies.
`default_nettype none
package amj_pkg;
	localparam int ROW_W = 12;
	localparam int CNT_W = 13;
	localparam int GID_W = 10;
	localparam int TS_W = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 63;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PROBE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_JOIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL = 2'd2;
	localparam logic [TS_W-1:0] SIGN64 = {1'b1, {(TS_W-1){1'b0}}};
endpackage
`default_nettype wire

FILE: hw/rtl/asof_merge_join.sv
// As-of merge join top level: sequencer, stores and one shared 64-bit compare/subtract.
// Depends on amj_pkg and amj_ram.
//
// channel | direction | signals
// config  | in        | cfg_we, cfg_index, cfg_data
// command | in, out   | start, operation..probe_row in; busy out
// result  | out       | result_valid, probe_row_out, build_row, matched, store_overflow
//
// Load and probe run through the sequencer states; probe time grows with each cursor step, set by the
// chained registered reads of the match list and time stores. After reset a clearing pass
// zeroes all 1024 entries of the group count store; busy stays high meanwhile.
// Results show for one cycle on result_valid; the receiver cannot stall.
`default_nettype none
module asof_merge_join
	import amj_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  operation,
	input  wire logic [GID_W-1:0]      group_id,
	input  wire logic                  group_found,
	input  wire logic                  key_valid,
	input  wire logic                  time_valid,
	input  wire logic [TS_W-1:0]       timestamp,
	input  wire logic [15:0]           probe_row,
	output logic                       result_valid,
	output logic [15:0]                probe_row_out,
	output logic [ROW_W-1:0]           build_row,
	output logic                       matched,
	output logic                       store_overflow
);
	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LD = 4'd2, S_PR = 4'd3,
		S_PR2 = 4'd4, S_ML = 4'd5, S_TM = 4'd6, S_CMP = 4'd7, S_CAND = 4'd8,
		S_CT = 4'd9, S_TOL = 4'd10, S_OUT = 4'd11, S_CMPT = 4'd12;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(13'd4096);

	logic [3:0] st_q;
	logic left_q, tol_en_q;
	logic [62:0] tol_q;
	logic [GID_W-1:0] gid_q, clr_q;
	logic [TS_W-1:0] tkey_q;
	logic [15:0] prow_q;
	logic kv_q, tv_q, group_found_q;
	logic [CNT_W-1:0] rows_q, fill_q, cpos_q, first_q, count_q;
	logic [GID_W-1:0] cgrp_q;
	logic cgv_q, ovf_q, hit_q;
	logic [ROW_W-1:0] cand_q;

	logic tm_we, ml_we, gf_we, gc_we;
	logic [ROW_W-1:0] tm_wa, tm_ra, ml_wa, ml_ra, ml_rd, gf_rd, gf_wd;
	logic [TS_W-1:0] tm_wd, tm_rdat;
	logic [GID_W-1:0] gc_wa;
	logic [CNT_W-1:0] gc_wd, gc_rd;
	logic [ROW_W-1:0] ml_wd;

	amj_ram #(.WIDTH(TS_W), .DEPTH(4096)) u_times (.clk, .we(tm_we), .waddr(tm_wa),
		.wdata(tm_wd), .raddr(tm_ra), .rdata(tm_rdat));
	amj_ram #(.WIDTH(ROW_W), .DEPTH(4096)) u_list (.clk, .we(ml_we), .waddr(ml_wa),
		.wdata(ml_wd), .raddr(ml_ra), .rdata(ml_rd));
	amj_ram #(.WIDTH(ROW_W), .DEPTH(1024)) u_first (.clk, .we(gf_we), .waddr(gid_q),
		.wdata(gf_wd), .raddr(gid_q), .rdata(gf_rd));
	amj_ram #(.WIDTH(CNT_W), .DEPTH(1024)) u_count (.clk, .we(gc_we), .waddr(gc_wa),
		.wdata(gc_wd), .raddr(gid_q), .rdata(gc_rd));

	// shared 64-bit unit: compare build time to key, or subtract for tolerance
	logic [TS_W:0] diff;
	assign diff = {1'b0, tkey_q} - {1'b0, tm_rdat};

	logic [CNT_W-1:0] list_addr;
	assign list_addr = first_q + cpos_q;
	logic [CNT_W-1:0] cnt_eff;
	logic new_grp;
	assign new_grp = !cgv_q || cgrp_q != gid_q;

	always_comb begin
		tm_we = 1'b0; ml_we = 1'b0; gf_we = 1'b0; gc_we = 1'b0;
		tm_wa = rows_q[ROW_W-1:0];
		tm_wd = tv_q ? tkey_q : SIGN64;
		ml_wa = fill_q[ROW_W-1:0];
		ml_wd = rows_q[ROW_W-1:0];
		gf_wd = fill_q[ROW_W-1:0];
		gc_wa = gid_q;
		gc_wd = gc_rd + CNT_W'(1);
		tm_ra = ml_rd;
		ml_ra = (st_q == S_CAND) ? ROW_W'(list_addr - CNT_W'(1)) : list_addr[ROW_W-1:0];
		cnt_eff = gc_rd;
		unique case (st_q)
			S_CLR: begin
				gc_we = 1'b1; gc_wa = clr_q; gc_wd = '0;
			end
			S_PR2: begin
				if (rows_q != FULL) begin
					tm_we = 1'b1;
					if (kv_q && tv_q && fill_q != FULL &&
						(gc_rd == '0 || CNT_W'(gf_rd) + gc_rd == fill_q)) begin
						ml_we = 1'b1; gc_we = 1'b1; gf_we = (gc_rd == '0);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; clr_q <= '0; left_q <= 1'b0; tol_en_q <= 1'b0; tol_q <= '0;
			rows_q <= '0; fill_q <= '0; cpos_q <= '0; cgrp_q <= '0; cgv_q <= 1'b0;
			ovf_q <= 1'b0; result_valid <= 1'b0;
			hit_q <= 1'b0; cand_q <= '0; first_q <= '0; count_q <= '0;
			probe_row_out <= '0; build_row <= '0; matched <= 1'b0; store_overflow <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LEFT_JOIN: left_q <= cfg_data[0];
					REG_TOL_EN: tol_en_q <= cfg_data[0];
					REG_TOL: tol_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + GID_W'(1);
					if (clr_q == '1) st_q <= S_IDLE;
				end
				S_IDLE: if (start) st_q <= (operation == OP_LOAD) ? S_LD : S_PR;
				S_LD: st_q <= S_PR2;
				S_PR2: begin
					if (rows_q == FULL) ovf_q <= 1'b1;
					else begin
						rows_q <= rows_q + CNT_W'(1);
						if (ml_we) fill_q <= fill_q + CNT_W'(1);
					end
					st_q <= S_IDLE;
				end
				S_PR: begin
					hit_q <= 1'b0;
					if (kv_q && tv_q && group_found_q) st_q <= S_ML;
					else st_q <= S_OUT;
				end
				S_ML: begin
					// group store read data is valid here
					first_q <= CNT_W'(gf_rd); count_q <= cnt_eff;
					if (new_grp) begin
						cgrp_q <= gid_q; cgv_q <= 1'b1; cpos_q <= '0;
					end
					st_q <= (cnt_eff == '0) ? S_OUT : S_TM;
				end
				S_TM: begin
					if (cpos_q >= count_q || list_addr >= FULL) st_q <= S_CAND;
					else st_q <= S_CMP;
				end
				S_CMP: st_q <= S_CT;
				S_CT: begin
					if (!diff[TS_W]) begin
						cpos_q <= cpos_q + CNT_W'(1); st_q <= S_TM;
					end else st_q <= S_CAND;
				end
				S_CAND: begin
					if (cpos_q == '0) st_q <= S_OUT;
					else st_q <= S_TOL;
				end
				S_TOL: begin
					cand_q <= ml_rd;
					st_q <= S_CMPT;
				end
				S_CMPT: begin
					hit_q <= !(tol_en_q && diff[TS_W-1:0] > {1'b0, tol_q});
					st_q <= S_OUT;
				end
				S_OUT: begin
					result_valid <= hit_q || left_q;
					probe_row_out <= prow_q;
					build_row <= hit_q ? cand_q : '0;
					matched <= hit_q;
					store_overflow <= ovf_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			gid_q <= group_id; kv_q <= key_valid; tv_q <= time_valid;
			tkey_q <= timestamp ^ SIGN64; prow_q <= probe_row; group_found_q <= group_found;
		end
	end

	assign busy = st_q != S_IDLE;

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ovf_q) |-> ovf_q) else $error("overflow flag cleared");
	a_fill_le_rows: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= rows_q) else $error("list fill beyond stored rows");
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$past(st_q == S_IDLE)) else $error("result without work");
endmodule
`default_nettype wire

FILE: hw/rtl/amj_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module amj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
